>>> rtl/stbs_pkg.sv
// ----------------------------------------------------------------------------
// Sorted table package
// Sizes, request and status codes, and the memory request structure shared
// by the sorted table blocks.
// ----------------------------------------------------------------------------
package stbs_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  // Signed width for the search bounds, which may step one below zero.
  localparam int SPAN_W      = IDX_W + 2;

  localparam int VAL_W       = 32;
  localparam int REQ_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int FIDX_W      = 7;
  localparam int ECNT_W      = 8;

  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic signed [VAL_W-1:0] wr_data;
    logic [IDX_W-1:0]        rd_addr;
  } ram_req_t;

endpackage

>>> rtl/stbs_channels.sv
// ----------------------------------------------------------------------------
// Sorted table channels
// Valid/ready channels for requests into the table and results out of it.
// ----------------------------------------------------------------------------
interface stbs_in_if import stbs_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface stbs_out_if import stbs_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [FIDX_W-1:0]   found_index;
  logic [ECNT_W-1:0]   entry_count;

  modport source (output valid, output status, output found_index,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input found_index,
                  input entry_count, output ready);
endinterface

>>> rtl/stbs_store.sv
// ----------------------------------------------------------------------------
// Sorted table value store
// Single write port, single read port memory with a registered read.
// ----------------------------------------------------------------------------
module stbs_store import stbs_pkg::*; (
  input  logic                    clk,
  input  ram_req_t                req,
  output logic signed [VAL_W-1:0] rd_data
);

  logic signed [VAL_W-1:0] mem [TABLE_DEPTH];
  logic signed [VAL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data_r <= mem[req.rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/sorted_table_binary_search.sv
// The result of an append, clear or unknown request is registered. A search of a
// sorted table of n entries checks the key against the first and the last entry,
// then makes one memory probe per binary search step, at most ceil(log2(n + 1))
// probes. The first search after an append to two or more entries first sorts in
// place through the single memory port pair. Reset empties the table and marks it
// sorted; the stored values are not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
// Sorted table with binary search
// Holds up to TABLE_DEPTH signed values in one memory, sorts them by exchange
// sort before a search when needed, and answers searches by binary search.
// ----------------------------------------------------------------------------
module sorted_table_binary_search import stbs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  stbs_in_if.sink    in_if,
  stbs_out_if.source out_if
);

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_SORT_GETI = 8'b0000_0010,
    S_SORT_SCAN = 8'b0000_0100,
    S_SORT_WRI  = 8'b0000_1000,
    S_SRCH_GO   = 8'b0001_0000,
    S_CHK_MIN   = 8'b0010_0000,
    S_CHK_MAX   = 8'b0100_0000,
    S_PROBE     = 8'b1000_0000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     sorted_r, sorted_nxt;
  logic signed [VAL_W-1:0]  key_r, key_nxt;
  logic signed [VAL_W-1:0]  cur_r, cur_nxt;
  logic [IDX_W-1:0]         i_r, i_nxt;
  logic [IDX_W-1:0]         j_r, j_nxt;
  logic signed [SPAN_W-1:0] lo_r, lo_nxt;
  logic signed [SPAN_W-1:0] hi_r, hi_nxt;
  logic [IDX_W-1:0]         mid_r, mid_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]      out_status_r, out_status_nxt;
  logic [FIDX_W-1:0]        out_fidx_r, out_fidx_nxt;
  logic [ECNT_W-1:0]        out_ecnt_r, out_ecnt_nxt;

  ram_req_t                 ram_req;
  logic signed [VAL_W-1:0]  rd_data;

  logic                     in_ready;
  logic                     accept;
  logic                     out_load;
  logic [STATUS_W-1:0]      res_status;
  logic [IDX_W-1:0]         res_idx;
  logic [CNT_W-1:0]         last_cnt;
  logic [IDX_W-1:0]         last_idx;
  logic signed [SPAN_W-1:0] mid_ext;
  logic signed [SPAN_W-1:0] new_lo;
  logic signed [SPAN_W-1:0] new_hi;
  logic signed [SPAN_W-1:0] bound_sum;

  stbs_store u_store (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  // The output register is free whenever the block is idle and either empty
  // or being drained by a transfer in this cycle.
  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_if.ready);
  assign accept   = in_if.valid && in_ready;

  assign last_cnt  = cnt_r - CNT_W'(1);
  assign last_idx  = last_cnt[IDX_W-1:0];
  assign mid_ext   = signed'({2'b00, mid_r});
  assign bound_sum = new_lo + new_hi;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    sorted_nxt     = sorted_r;
    key_nxt        = key_r;
    cur_nxt        = cur_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    ram_req.wr_en   = 1'b0;
    ram_req.wr_addr = cnt_r[IDX_W-1:0];
    ram_req.wr_data = in_if.value;
    ram_req.rd_addr = '0;
    out_load       = 1'b0;
    res_status     = ST_OK;
    res_idx        = '0;
    new_lo         = lo_r;
    new_hi         = hi_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_if.req_type)
            REQ_APPEND: begin
              out_load = 1'b1;
              if (cnt_r == CNT_W'(TABLE_DEPTH)) begin
                res_status = ST_FULL;
              end else begin
                ram_req.wr_en = 1'b1;
                cnt_nxt       = cnt_r + CNT_W'(1);
                sorted_nxt    = 1'b0;
              end
            end
            REQ_SEARCH: begin
              key_nxt = in_if.value;
              if (cnt_r == '0) begin
                out_load   = 1'b1;
                res_status = ST_EMPTY;
              end else if (!sorted_r && (cnt_r >= CNT_W'(2))) begin
                i_nxt     = '0;
                state_nxt = S_SORT_GETI;
              end else begin
                // A single entry is sorted by definition.
                sorted_nxt = 1'b1;
                state_nxt  = S_CHK_MIN;
              end
            end
            REQ_CLEAR: begin
              out_load   = 1'b1;
              cnt_nxt    = '0;
              sorted_nxt = 1'b1;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end

      S_SORT_GETI: begin
        cur_nxt         = rd_data;
        j_nxt           = i_r + IDX_W'(1);
        ram_req.rd_addr = i_r + IDX_W'(1);
        state_nxt       = S_SORT_SCAN;
      end

      S_SORT_SCAN: begin
        // Position i carries the running minimum; a larger held value moves
        // out to position j, exactly as a swap of the two entries would.
        if (cur_r > rd_data) begin
          ram_req.wr_en   = 1'b1;
          ram_req.wr_addr = j_r;
          ram_req.wr_data = cur_r;
          cur_nxt         = rd_data;
        end
        if (j_r == last_idx) begin
          state_nxt = S_SORT_WRI;
        end else begin
          j_nxt           = j_r + IDX_W'(1);
          ram_req.rd_addr = j_r + IDX_W'(1);
        end
      end

      S_SORT_WRI: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = i_r;
        ram_req.wr_data = cur_r;
        if ((i_r + IDX_W'(1)) == last_idx) begin
          sorted_nxt = 1'b1;
          state_nxt  = S_SRCH_GO;
        end else begin
          i_nxt           = i_r + IDX_W'(1);
          ram_req.rd_addr = i_r + IDX_W'(1);
          state_nxt       = S_SORT_GETI;
        end
      end

      S_SRCH_GO: begin
        state_nxt = S_CHK_MIN;
      end

      S_CHK_MIN: begin
        if (key_r < rd_data) begin
          out_load   = 1'b1;
          res_status = ST_MISS;
          state_nxt  = S_IDLE;
        end else begin
          ram_req.rd_addr = last_idx;
          state_nxt       = S_CHK_MAX;
        end
      end

      S_CHK_MAX: begin
        if (key_r > rd_data) begin
          out_load   = 1'b1;
          res_status = ST_MISS;
          state_nxt  = S_IDLE;
        end else begin
          lo_nxt          = '0;
          hi_nxt          = signed'(SPAN_W'(last_cnt));
          mid_nxt         = last_cnt[IDX_W:1];
          ram_req.rd_addr = last_cnt[IDX_W:1];
          state_nxt       = S_PROBE;
        end
      end

      S_PROBE: begin
        if (key_r == rd_data) begin
          out_load  = 1'b1;
          res_idx   = mid_r;
          state_nxt = S_IDLE;
        end else begin
          if (key_r < rd_data) begin
            new_hi = mid_ext - SPAN_W'(1);
          end else begin
            new_lo = mid_ext + SPAN_W'(1);
          end
          lo_nxt = new_lo;
          hi_nxt = new_hi;
          if (new_hi < new_lo) begin
            out_load   = 1'b1;
            res_status = ST_MISS;
            state_nxt  = S_IDLE;
          end else begin
            mid_nxt         = bound_sum[IDX_W:1];
            ram_req.rd_addr = bound_sum[IDX_W:1];
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_status_nxt = out_status_r;
    out_fidx_nxt   = out_fidx_r;
    out_ecnt_nxt   = out_ecnt_r;
    if (out_load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status;
      out_fidx_nxt   = FIDX_W'(res_idx);
      out_ecnt_nxt   = ECNT_W'(cnt_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sorted_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sorted_r    <= sorted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    cur_r        <= cur_nxt;
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    out_status_r <= out_status_nxt;
    out_fidx_r   <= out_fidx_nxt;
    out_ecnt_r   <= out_ecnt_nxt;
  end

  assign in_if.ready        = in_ready;
  assign out_if.valid       = out_valid_r;
  assign out_if.status      = out_status_r;
  assign out_if.found_index = out_fidx_r;
  assign out_if.entry_count = out_ecnt_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TABLE_DEPTH))
    else $error("held count exceeds the table depth");

  a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !out_valid_r)
    else $error("result pending while a search is still running");

  a_sort_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SORT_GETI || state_r == S_SORT_SCAN || state_r == S_SORT_WRI)
      |-> (cnt_r >= CNT_W'(2)) && !sorted_r)
    else $error("sort running on a table that needs none");

  a_probe_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE) |-> (lo_r <= mid_ext) && (mid_ext <= hi_r)
      && (hi_r < signed'(SPAN_W'(cnt_r))))
    else $error("binary search probe outside its bounds");
`endif

endmodule

>>> tb/stbs_result_check.sv
// ----------------------------------------------------------------------------
// Sorted table result checker
// Watches the request and result channels and keeps its own copy of the table.
// For every request transfer it works out the expected reply and queues it.
// Every result transfer is compared field by field with the oldest reply.
// ----------------------------------------------------------------------------
module stbs_result_check import stbs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  stbs_in_if   req_ch,
  stbs_out_if  res_ch,
  output int   mismatches,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FIDX_W-1:0]   found_index;
    logic [ECNT_W-1:0]   entry_count;
  } table_reply_t;

  logic signed [VAL_W-1:0] shadow_vals [TABLE_DEPTH];
  int           held_n    = 0;
  bit           in_order  = 1'b1;
  table_reply_t pending_replies [$];
  int           pending_n = 0;
  int           error_n   = 0;
  int           reply_n   = 0;

  assign mismatches  = error_n;
  assign outstanding = pending_n;

  task automatic report_error(input string msg);
    error_n++;
    $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  // Updates the shadow table for one request and returns the reply it causes.
  function automatic table_reply_t apply_request(input logic [REQ_W-1:0] req,
                                                 input logic signed [VAL_W-1:0] key);
    table_reply_t            r;
    logic signed [VAL_W-1:0] t;
    int                      lo, hi, mid;
    r = '0;
    case (req)
      REQ_APPEND: begin
        if (held_n >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_vals[held_n] = key;
          held_n++;
          in_order = 1'b0;
        end
      end
      REQ_SEARCH: begin
        if (held_n == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (!in_order) begin
            for (int i = 0; i < held_n; i++) begin
              for (int j = i + 1; j < held_n; j++) begin
                if (shadow_vals[i] > shadow_vals[j]) begin
                  t              = shadow_vals[i];
                  shadow_vals[i] = shadow_vals[j];
                  shadow_vals[j] = t;
                end
              end
            end
            in_order = 1'b1;
          end
          r.status = ST_MISS;
          if (key >= shadow_vals[0] && key <= shadow_vals[held_n-1]) begin
            lo = 0;
            hi = held_n - 1;
            while (lo <= hi && r.status == ST_MISS) begin
              mid = (lo + hi) / 2;
              if (key == shadow_vals[mid]) begin
                r.status      = ST_OK;
                r.found_index = mid[FIDX_W-1:0];
              end else if (key < shadow_vals[mid]) begin
                hi = mid - 1;
              end else begin
                lo = mid + 1;
              end
            end
          end
        end
      end
      REQ_CLEAR: begin
        held_n   = 0;
        in_order = 1'b1;
      end
      default: begin
        // The unused request code leaves the table alone.
      end
    endcase
    r.entry_count = held_n[ECNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    table_reply_t want;
    if (!rst_n) begin
      held_n   = 0;
      in_order = 1'b1;
      pending_replies.delete();
    end else begin
      // Results are registered, so a result transfer at this edge always
      // belongs to an earlier request.
      if (res_ch.valid && res_ch.ready) begin
        reply_n++;
        if (pending_replies.size() == 0) begin
          report_error($sformatf("result %0d arrived with no request waiting", reply_n));
        end else begin
          want = pending_replies.pop_front();
          if (res_ch.status !== want.status)
            report_error($sformatf("result %0d: status %0d, expected %0d",
                                   reply_n, res_ch.status, want.status));
          if (res_ch.found_index !== want.found_index)
            report_error($sformatf("result %0d: found_index %0d, expected %0d",
                                   reply_n, res_ch.found_index, want.found_index));
          if (res_ch.entry_count !== want.entry_count)
            report_error($sformatf("result %0d: entry_count %0d, expected %0d",
                                   reply_n, res_ch.entry_count, want.entry_count));
        end
      end
      if (req_ch.valid && req_ch.ready)
        pending_replies.push_back(apply_request(req_ch.req_type, req_ch.value));
    end
    pending_n = pending_replies.size();
  end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// Sorted table testbench top
// Drives append, search, clear and reserved requests into the sorted table:
// a short directed list of corner cases, then random load-and-probe sequences
// with random gaps on both channels. The result checker sits beside the block.
// ----------------------------------------------------------------------------
module tb_top import stbs_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  // The fourth request code has no meaning and must be ignored.
  localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;
  localparam int ITEM_TARGET  = 1750;
  localparam int STEADY_FIRST = 700;
  localparam int STEADY_LAST  = 950;

  logic clk = 1'b0;
  logic rst_n;
  bit   steady = 1'b0;
  int   issued = 0;
  int   mismatches;
  int   outstanding;
  logic signed [VAL_W-1:0] loaded_vals [$];

  stbs_in_if  req_ch ();
  stbs_out_if res_ch ();

  sorted_table_binary_search dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (req_ch),
    .out_if(res_ch)
  );

  stbs_result_check result_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_ch     (req_ch),
    .res_ch     (res_ch),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    res_ch.ready <= steady || ($urandom_range(99) >= 29);
  end

  // Presents one request and returns once its transfer has happened. Valid is
  // left high so that back-to-back requests need no gap.
  task automatic issue_request(input logic [REQ_W-1:0] req,
                               input logic signed [VAL_W-1:0] val);
    while (!steady && $urandom_range(99) < 29) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= req;
    req_ch.value    <= val;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (req != REQ_RESERVED)
      issued++;
    steady = (issued >= STEADY_FIRST && issued < STEADY_LAST);
  endtask

  task automatic append_value(input logic signed [VAL_W-1:0] val);
    issue_request(REQ_APPEND, val);
    if (loaded_vals.size() < TABLE_DEPTH)
      loaded_vals.push_back(val);
  endtask

  task automatic clear_table();
    issue_request(REQ_CLEAR, $urandom);
    loaded_vals.delete();
  endtask

  // Mostly keys that are held, some neighbors of held keys, some extremes, some anything.
  function automatic logic signed [VAL_W-1:0] pick_key();
    int r;
    int k;
    r = $urandom_range(99);
    if (loaded_vals.size() == 0 || r < 12)
      return $urandom;
    k = $urandom_range(loaded_vals.size() - 1);
    if (r < 70)
      return loaded_vals[k];
    if (r < 90)
      return ($urandom_range(1) == 1) ? loaded_vals[k] + 1 : loaded_vals[k] - 1;
    return (r < 95) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
  endfunction

  // One load-and-probe sequence. A fill sequence runs the table past full.
  task automatic run_sequence(input bit fill);
    int                      burst;
    bit                      narrow;
    logic signed [VAL_W-1:0] base;
    narrow = !fill && ($urandom_range(1) == 1);
    base   = $urandom;
    if (fill || loaded_vals.size() > 48 || $urandom_range(99) < 85) begin
      clear_table();
      if ($urandom_range(9) == 0)
        issue_request(REQ_SEARCH, $urandom);
    end
    if (fill) begin
      append_value(32'sh7FFF_FFFF);
      burst = TABLE_DEPTH + $urandom_range(1, 3);
    end else if ($urandom_range(99) < 75) begin
      burst = $urandom_range(1, 12);
    end else begin
      burst = $urandom_range(13, 40);
    end
    repeat ($urandom_range(1, 3)) begin
      // A narrow value range gives duplicates and near misses.
      repeat (burst) append_value(narrow ? base + $urandom_range(31) : $urandom);
      repeat ($urandom_range(3, 10)) issue_request(REQ_SEARCH, pick_key());
      if ($urandom_range(9) == 0)
        issue_request(REQ_RESERVED, $urandom);
      burst = $urandom_range(1, 6);
    end
    if (fill)
      issue_request(REQ_SEARCH, 32'sh7FFF_FFFF);
  endtask

  initial begin
    logic signed [VAL_W-1:0] corner_vals [5];
    corner_vals = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, -32'sd1, 32'sd5};
    rst_n           <= 1'b0;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_APPEND;
    req_ch.value    <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed corner cases.
    issue_request(REQ_SEARCH, 32'sd42);
    foreach (corner_vals[i]) append_value(corner_vals[i]);
    issue_request(REQ_SEARCH, 32'sh8000_0000);
    issue_request(REQ_SEARCH, 32'sh7FFF_FFFF);
    issue_request(REQ_SEARCH, -32'sd1);
    issue_request(REQ_SEARCH, 32'sd3);
    issue_request(REQ_SEARCH, 32'sd0);
    issue_request(REQ_RESERVED, 32'h5555_AAAA);
    clear_table();
    issue_request(REQ_SEARCH, 32'sd7);
    append_value(32'sd10);
    append_value(32'sd20);
    append_value(32'sd10);
    issue_request(REQ_SEARCH, 32'sd9);
    issue_request(REQ_SEARCH, 32'sd21);
    issue_request(REQ_SEARCH, 32'sd10);
    issue_request(REQ_SEARCH, 32'sd15);
    issue_request(REQ_SEARCH, 32'sd20);

    // Random sequences; the first one fills the table.
    for (int seq = 0; issued < ITEM_TARGET; seq++)
      run_sequence(seq == 0 || $urandom_range(99) < 2);

    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("sorted_table_binary_search test passed");
    else
      $display("sorted_table_binary_search test failed");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("sorted_table_binary_search test failed");
    $finish;
  end

endmodule
